// ===== hdl/ehwf_pkg.sv =====
// shared types, constants and window helpers for the event hit window filter
// no dependencies
`default_nettype none
package ehwf_pkg;

	localparam int NUM_DETECTORS = 512;
	localparam int DET_AW        = $clog2(NUM_DETECTORS);
	localparam int ID_W          = 9;
	localparam int CNT_W         = 20;
	localparam int SEL_W         = 10;
	localparam int WIN_W         = 40;
	localparam int EPOCH_W       = 8;
	localparam int IDX_W         = 3;

	localparam logic [CNT_W-1:0]   CNT_MAX       = '1;
	localparam logic [SEL_W-1:0]   SEL_MAX       = '1;
	localparam logic [CNT_W-1:0]   DISABLE_VALUE = 20'd999999;
	localparam logic [WIN_W-1:0]   WIN_RESET     = 40'd1048574951424;
	localparam logic [EPOCH_W-1:0] EPOCH_LAST    = '1;
	localparam logic [DET_AW-1:0]  ADDR_LAST     = DET_AW'(NUM_DETECTORS - 1);

	typedef enum logic [IDX_W-1:0] {
		REG_PIXEL,
		REG_DET_COUNT,
		REG_DET_HITS,
		REG_RING,
		REG_TRACK
	} reg_index_t;

	typedef struct packed {
		logic             has_hit;
		logic [ID_W-1:0]  detector_id;
		logic             last_of_event;
		logic             event_ok;
		logic             rings_present;
		logic [CNT_W-1:0] ring_count;
		logic [CNT_W-1:0] track_count;
	} hit_word_t;

	typedef struct packed {
		logic             passed;
		logic [CNT_W-1:0] hit_total;
		logic [SEL_W-1:0] selected_detectors;
	} result_word_t;

	typedef struct packed {
		logic [WIN_W-1:0] pixel_window;
		logic [WIN_W-1:0] detector_count_window;
		logic [WIN_W-1:0] detector_hits_window;
		logic [WIN_W-1:0] ring_window;
		logic [WIN_W-1:0] track_window;
	} window_set_t;

	typedef struct packed {
		logic [EPOCH_W-1:0] tag;
		logic [CNT_W-1:0]   cnt;
		logic               mark;
	} det_entry_t;

	typedef struct packed {
		logic              en;
		logic [DET_AW-1:0] addr;
		det_entry_t        data;
	} ram_write_t;

	function automatic logic [CNT_W-1:0] win_lo(input logic [WIN_W-1:0] w);
		return w[CNT_W-1:0];
	endfunction

	function automatic logic [CNT_W-1:0] win_hi(input logic [WIN_W-1:0] w);
		return w[WIN_W-1:CNT_W];
	endfunction

	function automatic logic in_window(input logic [WIN_W-1:0] w, input logic [CNT_W-1:0] v);
		return (v >= win_lo(w)) && (v <= win_hi(w));
	endfunction

	function automatic logic window_enabled(input logic [WIN_W-1:0] w);
		return (win_lo(w) != '0) || (win_hi(w) < DISABLE_VALUE);
	endfunction

endpackage
`default_nettype wire

// ===== hdl/ehwf_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none
module ehwf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== hdl/ehwf_count.sv =====
// counter stage: read-modify-write of the per-detector counters with forwarding,
// epoch tagging, clearing sweep, running totals and the end-of-event judgement; uses ehwf_pkg
`default_nettype none
module ehwf_count
	import ehwf_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         accept,
	input  wire hit_word_t    hit,
	input  wire window_set_t  win,
	input  wire det_entry_t   rd_entry,
	output logic [DET_AW-1:0] rd_addr,
	output ram_write_t        wr,
	output logic              push,
	output result_word_t      result,
	output logic              busy
);

	logic [ID_W+DET_AW-1:0] id_ext;
	logic                   id_in_range;

	logic              valid_s1;
	logic              fwd_s1;
	hit_word_t         hit_s1;
	logic [DET_AW-1:0] addr_s1;
	logic              in_range_s1;
	det_entry_t        fwd_entry_s1;

	logic [EPOCH_W-1:0] epoch_q;
	logic [CNT_W-1:0]   total_q;
	logic [SEL_W-1:0]   sel_q;
	logic               clr_active_q;
	logic [DET_AW-1:0]  clr_addr_q;

	det_entry_t       ent_raw;
	logic             ent_live;
	logic [CNT_W-1:0] cnt_old;
	logic             mark_old;
	logic [CNT_W-1:0] cnt_new;
	logic             sel_now;
	logic             det_upd;
	logic [CNT_W-1:0] total_nx;
	logic [SEL_W-1:0] sel_nx;
	logic             ok;
	logic             wrap;

	assign id_ext      = (ID_W + DET_AW)'(hit.detector_id);
	assign id_in_range = id_ext < (ID_W + DET_AW)'(NUM_DETECTORS);
	assign rd_addr     = id_ext[DET_AW-1:0];

	always_comb begin
		ent_raw  = fwd_s1 ? fwd_entry_s1 : rd_entry;
		ent_live = ent_raw.tag == epoch_q;
		cnt_old  = ent_live ? ent_raw.cnt : '0;
		mark_old = ent_live & ent_raw.mark;
		cnt_new  = (cnt_old == CNT_MAX) ? cnt_old : cnt_old + 1'b1;
		sel_now  = !mark_old && (cnt_new > win_lo(win.detector_hits_window))
			&& (cnt_new < win_hi(win.detector_hits_window));
		det_upd  = valid_s1 & hit_s1.has_hit & in_range_s1;

		total_nx = total_q;
		if (valid_s1 && hit_s1.has_hit && total_q != CNT_MAX) begin
			total_nx = total_q + 1'b1;
		end
		sel_nx = sel_q;
		if (det_upd && sel_now && sel_q != SEL_MAX) begin
			sel_nx = sel_q + 1'b1;
		end

		if (clr_active_q) begin
			wr.en   = 1'b1;
			wr.addr = clr_addr_q;
			wr.data = '0;
		end else begin
			wr.en        = det_upd;
			wr.addr      = addr_s1;
			wr.data.tag  = epoch_q;
			wr.data.cnt  = cnt_new;
			wr.data.mark = mark_old | sel_now;
		end

		ok = hit_s1.event_ok && in_window(win.pixel_window, total_nx);
		if (window_enabled(win.detector_count_window)) begin
			ok = ok && in_window(win.detector_count_window, CNT_W'(sel_nx));
		end
		if (window_enabled(win.ring_window)) begin
			ok = ok && hit_s1.rings_present && in_window(win.ring_window, hit_s1.ring_count);
		end
		if (window_enabled(win.track_window)) begin
			ok = ok && in_window(win.track_window, hit_s1.track_count);
		end

		push                      = valid_s1 & hit_s1.last_of_event;
		result.passed             = ok;
		result.hit_total          = total_nx;
		result.selected_detectors = sel_nx;

		wrap = push && (epoch_q == EPOCH_LAST);
		busy = clr_active_q | wrap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			fwd_s1       <= 1'b0;
			epoch_q      <= '0;
			total_q      <= '0;
			sel_q        <= '0;
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else begin
			valid_s1 <= accept;
			fwd_s1   <= accept && wr.en && (wr.addr == rd_addr);
			if (push) begin
				epoch_q <= epoch_q + 1'b1;
				total_q <= '0;
				sel_q   <= '0;
			end else begin
				total_q <= total_nx;
				sel_q   <= sel_nx;
			end
			if (clr_active_q) begin
				if (clr_addr_q == ADDR_LAST) begin
					clr_active_q <= 1'b0;
					clr_addr_q   <= '0;
				end else begin
					clr_addr_q <= clr_addr_q + 1'b1;
				end
			end else if (wrap) begin
				clr_active_q <= 1'b1;
				clr_addr_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_s1       <= hit;
			addr_s1      <= rd_addr;
			in_range_s1  <= id_in_range;
			fwd_entry_s1 <= wr.data;
		end
	end

	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> !accept)
		else $error("item accepted during clearing sweep");

	a_wrap_starts_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(push && epoch_q == EPOCH_LAST) |=> clr_active_q)
		else $error("epoch wrap without clearing sweep");

	a_sel_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(sel_q) <= total_q)
		else $error("selected count above hit total");

	a_fwd_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> valid_s1)
		else $error("forward flag without item");

endmodule
`default_nettype wire

// ===== hdl/ehwf_outq.sv =====
// two-entry result queue between the counter stage and the result channel
// uses ehwf_pkg
`default_nettype none
module ehwf_outq
	import ehwf_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire result_word_t  push_word,
	output logic               res_valid,
	input  wire logic          res_stall,
	output result_word_t       res,
	output logic [1:0]         level
);

	result_word_t slot0_q;
	result_word_t slot1_q;
	logic [1:0]   cnt_q;
	logic         pop;

	assign res_valid = cnt_q != 2'd0;
	assign res       = slot0_q;
	assign pop       = res_valid & !res_stall;
	assign level     = cnt_q - {1'b0, pop};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= level + {1'b0, push};
		end
	end

	always_ff @(posedge clk) begin
		if (pop && cnt_q == 2'd2) begin
			slot0_q <= slot1_q;
		end
		if (push) begin
			if (level == 2'd0) begin
				slot0_q <= push_word;
			end else begin
				slot1_q <= push_word;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> level < 2'd2)
		else $error("result queue overflow");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result queue count out of range");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> res_valid)
		else $error("pushed word not visible");

endmodule
`default_nettype wire

// ===== hdl/event_hit_window_filter.sv =====
// result path: hit word into the counter stage register, result word into the queue
// throughput: one hit word per cycle while hit_stall is low
// stall: while the counter ram is swept after reset and after every 256th event
// (8-bit epoch tags wrap); also while the result queue is full or filling
// reset: asynchronous, active low; windows return to max 999999, min 0; configuration
// writes are taken at any time
`default_nettype none
module event_hit_window_filter
	import ehwf_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             hit_valid,
	output logic                  hit_stall,
	input  wire hit_word_t        hit,
	output logic                  res_valid,
	input  wire logic             res_stall,
	output result_word_t          res,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [WIN_W-1:0] cfg_data
);

	window_set_t       win_q;
	logic              accept;
	logic              busy;
	logic              push;
	result_word_t      push_word;
	logic [1:0]        level;
	logic [DET_AW-1:0] rd_addr;
	ram_write_t        wr;
	logic [$bits(det_entry_t)-1:0] rd_data;
	det_entry_t        rd_entry;

	assign cfg_ready = 1'b1;
	assign hit_stall = busy || (level == 2'd2) || (level == 2'd1 && push);
	assign accept    = hit_valid & !hit_stall;
	assign rd_entry  = det_entry_t'(rd_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q.pixel_window          <= WIN_RESET;
			win_q.detector_count_window <= WIN_RESET;
			win_q.detector_hits_window  <= WIN_RESET;
			win_q.ring_window           <= WIN_RESET;
			win_q.track_window          <= WIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_index_t'(cfg_index))
				REG_PIXEL:     win_q.pixel_window          <= cfg_data;
				REG_DET_COUNT: win_q.detector_count_window <= cfg_data;
				REG_DET_HITS:  win_q.detector_hits_window  <= cfg_data;
				REG_RING:      win_q.ring_window           <= cfg_data;
				REG_TRACK:     win_q.track_window          <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	ehwf_ram #(
		.WIDTH($bits(det_entry_t)),
		.DEPTH(NUM_DETECTORS)
	) u_ram (
		.clk  (clk),
		.we   (wr.en),
		.waddr(wr.addr),
		.wdata(wr.data),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	ehwf_count u_count (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.hit     (hit),
		.win     (win_q),
		.rd_entry(rd_entry),
		.rd_addr (rd_addr),
		.wr      (wr),
		.push    (push),
		.result  (push_word),
		.busy    (busy)
	);

	ehwf_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_word(push_word),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res),
		.level    (level)
	);

endmodule
`default_nettype wire
